// ----- rtl/albc_pkg.sv -----
// Shared types and constants of the ladder keypad press classifier.
// No dependencies; imported by the top level and its checker.
package albc_pkg;

    localparam int NBTN   = 4;
    localparam int THR_W  = 12;
    localparam int MS_W   = 16;
    localparam int CLR_W  = 9;
    localparam int KEY_W  = 3;
    localparam int CNT_W  = 16;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_SHORT = 2'd1,
        CLS_LONG  = 2'd2,
        CLS_HELD  = 2'd3
    } t_press_class;

    localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;
    localparam logic [KEY_W-1:0] KEY_1    = 3'd1;
    localparam logic [KEY_W-1:0] KEY_2    = 3'd2;
    localparam logic [KEY_W-1:0] KEY_3    = 3'd3;
    localparam logic [KEY_W-1:0] KEY_4    = 3'd4;

    localparam logic [2:0] REG_IDLE  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_KEY4  = 3'd4;
    localparam logic [2:0] REG_LONG  = 3'd5;
    localparam logic [2:0] REG_HOLD  = 3'd6;
    localparam logic [2:0] REG_CLEAR = 3'd7;

    localparam logic [THR_W-1:0] RST_IDLE  = 12'd3847;
    localparam logic [THR_W-1:0] RST_KEY1  = 12'd3599;
    localparam logic [THR_W-1:0] RST_KEY2  = 12'd1862;
    localparam logic [THR_W-1:0] RST_KEY3  = 12'd1241;
    localparam logic [THR_W-1:0] RST_KEY4  = 12'd621;
    localparam logic [MS_W-1:0]  RST_LONG  = 16'd1500;
    localparam logic [MS_W-1:0]  RST_HOLD  = 16'd500;
    localparam logic [CLR_W-1:0] RST_CLEAR = 9'd300;

endpackage

// ----- rtl/adc_ladder_button_classifier_top.sv -----
// Ladder keypad press classifier: decode, per-button press logic, APB registers.
// Depends on albc_pkg.
//
// Takes one word per clock cycle while o_in_ready is high. A word lands in an
// input register; once the output side is free, the key decode and the update
// of all four buttons run in one pass and the result word is registered, so
// the block sustains one word per cycle while the output side takes them. The
// button state itself is the output register for class and repeat count, so a
// stalled output holds the input stage, and o_in_ready follows i_out_ready
// combinationally once both registers are full. The user must write configuration
// over APB only while no word is in flight; the block itself does not enforce this.
module adc_ladder_button_classifier_top #(
    parameter int ADC_BITS  = 12,
    parameter int TIME_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ADC_BITS-1:0]          i_adc_sample,
    input  logic [TIME_BITS-1:0]         i_now_ms,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [albc_pkg::KEY_W-1:0]   o_key_code,
    output logic [1:0]                   o_class_b1,
    output logic [1:0]                   o_class_b2,
    output logic [1:0]                   o_class_b3,
    output logic [1:0]                   o_class_b4,
    output logic [albc_pkg::CNT_W-1:0]   o_repeats_b1,
    output logic [albc_pkg::CNT_W-1:0]   o_repeats_b2,
    output logic [albc_pkg::CNT_W-1:0]   o_repeats_b3,
    output logic [albc_pkg::CNT_W-1:0]   o_repeats_b4,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [albc_pkg::ADDR_W-1:0]  paddr,
    input  logic [albc_pkg::DATA_W-1:0]  pwdata,
    output logic [albc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import albc_pkg::*;

    localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

    logic [THR_W-1:0] r_thr_idle, r_thr_k1, r_thr_k2, r_thr_k3, r_thr_k4;
    logic [MS_W-1:0]  r_long, r_hold;
    logic [CLR_W-1:0] r_clear;

    logic                 r_in_valid;
    logic [ADC_BITS-1:0]  r_in_adc;
    logic [TIME_BITS-1:0] r_in_now;
    logic                 r_out_valid;
    logic [KEY_W-1:0]     r_out_key;

    logic                 r_prev_lvl [NBTN];
    logic [TIME_BITS-1:0] r_start    [NBTN];
    logic [TIME_BITS-1:0] r_mark     [NBTN];
    t_press_class         r_class    [NBTN];
    logic [CNT_W-1:0]     r_rep      [NBTN];
    logic [CLR_W-1:0]     r_clr      [NBTN];

    logic                 n_prev_lvl [NBTN];
    logic [TIME_BITS-1:0] n_start    [NBTN];
    logic [TIME_BITS-1:0] n_mark     [NBTN];
    t_press_class         n_class    [NBTN];
    logic [CNT_W-1:0]     n_rep      [NBTN];
    logic [CLR_W-1:0]     n_clr      [NBTN];

    logic [TIME_BITS-1:0] w_rep_el   [NBTN];
    logic [TIME_BITS-1:0] w_held_el  [NBTN];
    logic [NBTN-1:0]      w_pressed;
    logic [KEY_W-1:0]     w_key;
    logic [CMP_W-1:0]     w_code;
    logic                 w_out_free;
    logic                 w_move;
    logic                 w_cfg_wr;
    logic [2:0]           w_reg_idx;

    // handshake
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_move      = r_in_valid && w_out_free;
    assign o_in_ready  = !r_in_valid || w_out_free;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_adc <= i_adc_sample;
            r_in_now <= i_now_ms;
        end
        if (w_move) begin
            r_out_key <= w_key;
        end
    end

    // key decode, first threshold reached wins
    assign w_code = CMP_W'(r_in_adc);

    always_comb begin
        priority if (w_code >= CMP_W'(r_thr_idle)) w_key = KEY_NONE;
        else if (w_code >= CMP_W'(r_thr_k1))       w_key = KEY_1;
        else if (w_code >= CMP_W'(r_thr_k2))       w_key = KEY_2;
        else if (w_code >= CMP_W'(r_thr_k3))       w_key = KEY_3;
        else if (w_code >= CMP_W'(r_thr_k4))       w_key = KEY_4;
        else                                       w_key = KEY_NONE;
    end

    always_comb begin
        for (int b = 0; b < NBTN; b++) begin
            w_pressed[b] = (w_key == KEY_W'(b + 1));
            w_rep_el[b]  = r_in_now - r_mark[b];
            w_held_el[b] = r_in_now - r_start[b];
        end
    end

    // per-button press classifier
    always_comb begin
        for (int b = 0; b < NBTN; b++) begin
            n_prev_lvl[b] = !w_pressed[b];
            n_start[b]    = r_start[b];
            n_mark[b]     = r_mark[b];
            n_class[b]    = r_class[b];
            n_rep[b]      = r_rep[b];
            n_clr[b]      = r_clr[b];
            if (w_pressed[b]) begin
                if (r_prev_lvl[b]) begin
                    n_start[b] = r_in_now;
                    n_mark[b]  = r_in_now;
                    n_rep[b]   = '0;
                end else if (w_rep_el[b] > TIME_BITS'(r_hold)) begin
                    n_mark[b]  = r_in_now;
                    n_class[b] = CLS_HELD;
                    n_rep[b]   = r_rep[b] + CNT_W'(1);
                end
            end else if (!r_prev_lvl[b]) begin
                n_class[b] = (w_held_el[b] > TIME_BITS'(r_long)) ? CLS_LONG : CLS_SHORT;
                n_clr[b]   = '0;
            end
            if (n_class[b] == CLS_LONG || n_class[b] == CLS_SHORT) begin
                n_clr[b] = n_clr[b] + CLR_W'(1);
                if (n_clr[b] >= r_clear) begin
                    n_class[b] = CLS_NONE;
                    n_clr[b]   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NBTN; b++) begin
                r_prev_lvl[b] <= 1'b1;
                r_start[b]    <= '0;
                r_mark[b]     <= '0;
                r_class[b]    <= CLS_NONE;
                r_rep[b]      <= '0;
                r_clr[b]      <= '0;
            end
        end else if (w_move) begin
            for (int b = 0; b < NBTN; b++) begin
                r_prev_lvl[b] <= n_prev_lvl[b];
                r_start[b]    <= n_start[b];
                r_mark[b]     <= n_mark[b];
                r_class[b]    <= n_class[b];
                r_rep[b]      <= n_rep[b];
                r_clr[b]      <= n_clr[b];
            end
        end
    end

    assign o_key_code   = r_out_key;
    assign o_class_b1   = r_class[0];
    assign o_class_b2   = r_class[1];
    assign o_class_b3   = r_class[2];
    assign o_class_b4   = r_class[3];
    assign o_repeats_b1 = r_rep[0];
    assign o_repeats_b2 = r_rep[1];
    assign o_repeats_b3 = r_rep[2];
    assign o_repeats_b4 = r_rep[3];

    // APB registers
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_idle <= RST_IDLE;
            r_thr_k1   <= RST_KEY1;
            r_thr_k2   <= RST_KEY2;
            r_thr_k3   <= RST_KEY3;
            r_thr_k4   <= RST_KEY4;
            r_long     <= RST_LONG;
            r_hold     <= RST_HOLD;
            r_clear    <= RST_CLEAR;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_IDLE:  r_thr_idle <= pwdata[THR_W-1:0];
                REG_KEY1:  r_thr_k1   <= pwdata[THR_W-1:0];
                REG_KEY2:  r_thr_k2   <= pwdata[THR_W-1:0];
                REG_KEY3:  r_thr_k3   <= pwdata[THR_W-1:0];
                REG_KEY4:  r_thr_k4   <= pwdata[THR_W-1:0];
                REG_LONG:  r_long     <= pwdata[MS_W-1:0];
                REG_HOLD:  r_hold     <= pwdata[MS_W-1:0];
                REG_CLEAR: r_clear    <= pwdata[CLR_W-1:0];
                default:   r_clear    <= r_clear;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_IDLE:  prdata = DATA_W'(r_thr_idle);
            REG_KEY1:  prdata = DATA_W'(r_thr_k1);
            REG_KEY2:  prdata = DATA_W'(r_thr_k2);
            REG_KEY3:  prdata = DATA_W'(r_thr_k3);
            REG_KEY4:  prdata = DATA_W'(r_thr_k4);
            REG_LONG:  prdata = DATA_W'(r_long);
            REG_HOLD:  prdata = DATA_W'(r_hold);
            REG_CLEAR: prdata = DATA_W'(r_clear);
            default:   prdata = '0;
        endcase
    end

endmodule

// ----- rtl/albc_checker.sv -----
// Port-level checks of the ladder keypad press classifier, bound to the top level.
// Depends on albc_pkg and adc_ladder_button_classifier_top.
module albc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [albc_pkg::KEY_W-1:0]  o_key_code,
    input logic [1:0]                  o_class_b1,
    input logic [1:0]                  o_class_b2,
    input logic [1:0]                  o_class_b3,
    input logic [1:0]                  o_class_b4
);
    import albc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_key_code))
        else $error("result word dropped or changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_key_code <= KEY_4)
        else $error("key code out of range");

    a_held_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_class_b1 != CLS_HELD || o_key_code == KEY_1) &&
            (o_class_b2 != CLS_HELD || o_key_code == KEY_2) &&
            (o_class_b3 != CLS_HELD || o_key_code == KEY_3) &&
            (o_class_b4 != CLS_HELD || o_key_code == KEY_4))
        else $error("held class on a button that is not pressed");

endmodule

bind adc_ladder_button_classifier_top albc_checker u_albc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_key_code  (o_key_code),
    .o_class_b1  (o_class_b1),
    .o_class_b2  (o_class_b2),
    .o_class_b3  (o_class_b3),
    .o_class_b4  (o_class_b4)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of adc_ladder_button_classifier_top: scan words in, press reports out.
// Depends on albc_pkg and the top level; predicts every report and compares it field by field.
module tb_top;
    import albc_pkg::*;

    localparam int ADC_W       = 12;
    localparam int TIME_W      = 32;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [ADC_W-1:0]  adc;
        logic [TIME_W-1:0] now;
    } t_scan_tick;

    typedef struct packed {
        logic [KEY_W-1:0]            key;
        logic [NBTN-1:0][1:0]        cls;
        logic [NBTN-1:0][CNT_W-1:0]  reps;
    } t_key_report;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [ADC_W-1:0]    i_adc_sample = '0;
    logic [TIME_W-1:0]   i_now_ms     = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [KEY_W-1:0]    o_key_code;
    logic [1:0]          o_class_b1, o_class_b2, o_class_b3, o_class_b4;
    logic [CNT_W-1:0]    o_repeats_b1, o_repeats_b2, o_repeats_b3, o_repeats_b4;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic [THR_W-1:0]    thr_cfg [5] = '{RST_IDLE, RST_KEY1, RST_KEY2, RST_KEY3, RST_KEY4};
    logic [MS_W-1:0]     long_cfg    = RST_LONG;
    logic [MS_W-1:0]     hold_cfg    = RST_HOLD;
    logic [CLR_W-1:0]    clear_cfg   = RST_CLEAR;

    logic                btn_up    [NBTN] = '{default: 1'b1};
    logic [TIME_W-1:0]   press_t0  [NBTN] = '{default: '0};
    logic [TIME_W-1:0]   rep_t     [NBTN] = '{default: '0};
    t_press_class        btn_class [NBTN] = '{default: CLS_NONE};
    logic [CNT_W-1:0]    rep_cnt   [NBTN] = '{default: '0};
    logic [CLR_W-1:0]    clr_cnt   [NBTN] = '{default: '0};

    t_scan_tick          scan_ticks[$];
    t_key_report         predicted_reports[$];
    int                  ticks_queued = 0;
    int                  ticks_taken  = 0;
    int                  faults       = 0;
    int                  send_gap     = 0;
    int                  recv_hold    = 0;
    bit                  send_quiet   = 1'b0;
    bit                  recv_quiet   = 1'b0;
    int                  idle_cycles  = 0;
    logic [TIME_W-1:0]   scan_clock   = '0;

    adc_ladder_button_classifier_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_adc_sample (i_adc_sample),
        .i_now_ms     (i_now_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_key_code   (o_key_code),
        .o_class_b1   (o_class_b1),
        .o_class_b2   (o_class_b2),
        .o_class_b3   (o_class_b3),
        .o_class_b4   (o_class_b4),
        .o_repeats_b1 (o_repeats_b1),
        .o_repeats_b2 (o_repeats_b2),
        .o_repeats_b3 (o_repeats_b3),
        .o_repeats_b4 (o_repeats_b4),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [KEY_W-1:0] decode_ladder(input logic [ADC_W-1:0] code);
        if (code >= thr_cfg[REG_IDLE]) return KEY_NONE;
        if (code >= thr_cfg[REG_KEY1]) return KEY_1;
        if (code >= thr_cfg[REG_KEY2]) return KEY_2;
        if (code >= thr_cfg[REG_KEY3]) return KEY_3;
        if (code >= thr_cfg[REG_KEY4]) return KEY_4;
        return KEY_NONE;
    endfunction

    function automatic logic [ADC_W-1:0] sample_for(input logic [KEY_W-1:0] key);
        logic [ADC_W-1:0] start;
        logic [ADC_W-1:0] code;
        start = ADC_W'($urandom_range(0, 4095));
        for (int i = 0; i < 4096; i++) begin
            code = start + ADC_W'(i);
            if (decode_ladder(code) == key) return code;
        end
        return start;
    endfunction

    function automatic int draw_pause(inout bit quiet);
        if ($urandom_range(0, 15) == 0) quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 3);
    endfunction

    task automatic classify_tick(input logic [ADC_W-1:0] code, input logic [TIME_W-1:0] now);
        t_key_report       rpt;
        logic [KEY_W-1:0]  key;
        logic              pressed;
        logic [TIME_W-1:0] elapsed;
        key = decode_ladder(code);
        for (int b = 0; b < NBTN; b++) begin
            pressed = (key == KEY_W'(b + 1));
            if (pressed) begin
                if (btn_up[b]) begin
                    press_t0[b] = now;
                    rep_t[b]    = now;
                    rep_cnt[b]  = '0;
                end else begin
                    elapsed = now - rep_t[b];
                    if (elapsed > TIME_W'(hold_cfg)) begin
                        rep_t[b]     = now;
                        btn_class[b] = CLS_HELD;
                        rep_cnt[b]   = rep_cnt[b] + CNT_W'(1);
                    end
                end
            end else if (!btn_up[b]) begin
                elapsed = now - press_t0[b];
                if (elapsed > TIME_W'(long_cfg)) btn_class[b] = CLS_LONG;
                else btn_class[b] = CLS_SHORT;
                clr_cnt[b] = '0;
            end
            btn_up[b] = !pressed;
            if (btn_class[b] == CLS_LONG || btn_class[b] == CLS_SHORT) begin
                clr_cnt[b] = clr_cnt[b] + CLR_W'(1);
                if (clr_cnt[b] >= clear_cfg) begin
                    btn_class[b] = CLS_NONE;
                    clr_cnt[b]   = '0;
                end
            end
            rpt.cls[b]  = btn_class[b];
            rpt.reps[b] = rep_cnt[b];
        end
        rpt.key = key;
        predicted_reports.push_back(rpt);
    endtask

    task automatic push_tick(input logic [ADC_W-1:0] code, input logic [TIME_W-1:0] now);
        scan_ticks.push_back({code, now});
        ticks_queued++;
    endtask

    // Mostly press/hold/release runs with random timing; some noise and key hops.
    task automatic queue_random_ticks(input int count);
        int               made;
        int               pick;
        int               run_len;
        int               step_max;
        logic [KEY_W-1:0] key;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                push_tick(ADC_W'($urandom), $urandom);
                made++;
            end else begin
                if ($urandom_range(0, 7) == 0)
                    scan_clock = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 4000));
                case ($urandom_range(0, 3))
                    0: step_max = 50;
                    1: step_max = 400;
                    2: step_max = 1200;
                    default: step_max = $urandom_range(0, 70000);
                endcase
                key     = KEY_W'($urandom_range(1, 4));
                run_len = $urandom_range(1, 8);
                repeat (run_len) begin
                    scan_clock = scan_clock + TIME_W'($urandom_range(0, step_max));
                    push_tick(sample_for(key), scan_clock);
                end
                scan_clock = scan_clock + TIME_W'($urandom_range(0, step_max));
                if (pick == 1) push_tick(sample_for(KEY_W'($urandom_range(0, 4))), scan_clock);
                else push_tick(sample_for(KEY_NONE), scan_clock);
                made += run_len + 1;
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_IDLE, REG_KEY1, REG_KEY2, REG_KEY3, REG_KEY4: thr_cfg[idx] = val[THR_W-1:0];
            REG_LONG:  long_cfg  = val[MS_W-1:0];
            REG_HOLD:  hold_cfg  = val[MS_W-1:0];
            REG_CLEAR: clear_cfg = val[CLR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [THR_W-1:0] idle, k1, k2, k3, k4,
                                  input logic [MS_W-1:0] lng, hold,
                                  input logic [CLR_W-1:0] clr);
        write_reg(REG_IDLE,  DATA_W'(idle));
        write_reg(REG_KEY1,  DATA_W'(k1));
        write_reg(REG_KEY2,  DATA_W'(k2));
        write_reg(REG_KEY3,  DATA_W'(k3));
        write_reg(REG_KEY4,  DATA_W'(k4));
        write_reg(REG_LONG,  DATA_W'(lng));
        write_reg(REG_HOLD,  DATA_W'(hold));
        write_reg(REG_CLEAR, DATA_W'(clr));
    endtask

    task automatic await_drain();
        while (!(ticks_taken == ticks_queued && predicted_reports.size() == 0))
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_scan_tick next_tick;
        logic       keep;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            keep = i_in_valid && !o_in_ready;
            if (i_in_valid && o_in_ready) begin
                classify_tick(i_adc_sample, i_now_ms);
                ticks_taken++;
            end
            if (!keep) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (scan_ticks.size() > 0) begin
                    next_tick    = scan_ticks.pop_front();
                    i_adc_sample <= next_tick.adc;
                    i_now_ms     <= next_tick.now;
                    keep         = 1'b1;
                    send_gap     = draw_pause(send_quiet);
                end
            end
            i_in_valid <= keep;
        end
    end

    always @(posedge i_clk) begin
        t_key_report                want;
        logic [NBTN-1:0][1:0]       got_cls;
        logic [NBTN-1:0][CNT_W-1:0] got_reps;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got_cls  = {o_class_b4, o_class_b3, o_class_b2, o_class_b1};
                got_reps = {o_repeats_b4, o_repeats_b3, o_repeats_b2, o_repeats_b1};
                if (predicted_reports.size() == 0) begin
                    $error("report word with none pending");
                    faults++;
                end else begin
                    want = predicted_reports.pop_front();
                    if (o_key_code !== want.key) begin
                        $error("key_code: expected %0d, got %0d", want.key, o_key_code);
                        faults++;
                    end
                    for (int b = 0; b < NBTN; b++) begin
                        if (got_cls[b] !== want.cls[b]) begin
                            $error("class_b%0d: expected %0d, got %0d",
                                   b + 1, want.cls[b], got_cls[b]);
                            faults++;
                        end
                        if (got_reps[b] !== want.reps[b]) begin
                            $error("repeats_b%0d: expected %0d, got %0d",
                                   b + 1, want.reps[b], got_reps[b]);
                            faults++;
                        end
                    end
                end
                recv_hold = draw_pause(recv_quiet);
            end
            if (recv_hold > 0) begin
                recv_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds: edges of every key band
        push_tick(12'd4095, 32'd0);
        push_tick(12'd0,    32'd10);
        push_tick(12'd620,  32'd20);
        push_tick(12'd3847, 32'd30);
        push_tick(12'd3846, 32'd40);
        push_tick(12'd3599, 32'd100);
        push_tick(12'd3598, 32'd200);
        push_tick(12'd1862, 32'd300);
        push_tick(12'd1861, 32'd400);
        push_tick(12'd1241, 32'd450);
        push_tick(12'd1240, 32'd500);
        push_tick(12'd621,  32'd600);
        push_tick(12'd4095, 32'd700);
        // press, held repeats, held release turning long
        push_tick(12'd3700, 32'd1000);
        push_tick(12'd3700, 32'd1501);
        push_tick(12'd3700, 32'd2002);
        push_tick(12'd3700, 32'd2600);
        push_tick(12'd0,    32'd2700);
        // hold and release across the time wrap
        push_tick(12'd1500, 32'hFFFF_FF00);
        push_tick(12'd1500, 32'h0000_0200);
        push_tick(12'd4000, 32'h0000_0300);
        scan_clock = 32'd5000;
        queue_random_ticks(90);
        await_drain();

        apply_settings(12'd4095, 12'd3000, 12'd2000, 12'd1000, 12'd0,
                       16'hFFFF, 16'hFFFF, 9'd511);
        queue_random_ticks(80);
        await_drain();

        // thresholds out of order, zero times, class clears on the tick it is set
        apply_settings(12'd4095, 12'd1000, 12'd3000, 12'd2000, 12'd500,
                       16'd0, 16'd0, 9'd0);
        push_tick(12'd3500, scan_clock + 32'd10);
        push_tick(12'd3500, scan_clock + 32'd11);
        push_tick(12'd4095, scan_clock + 32'd12);
        push_tick(12'd600,  scan_clock + 32'd20);
        push_tick(12'd100,  scan_clock + 32'd20);
        scan_clock = scan_clock + 32'd30;
        queue_random_ticks(60);
        await_drain();

        apply_settings(THR_W'($urandom_range(0, 4095)), THR_W'($urandom_range(0, 4095)),
                       THR_W'($urandom_range(0, 4095)), THR_W'($urandom_range(0, 4095)),
                       THR_W'($urandom_range(0, 4095)), MS_W'($urandom_range(0, 3000)),
                       MS_W'($urandom_range(0, 1000)), CLR_W'($urandom_range(1, 20)));
        queue_random_ticks(80);
        await_drain();

        apply_settings(12'd0, THR_W'($urandom_range(0, 4095)),
                       THR_W'($urandom_range(0, 4095)), THR_W'($urandom_range(0, 4095)),
                       THR_W'($urandom_range(0, 4095)), MS_W'($urandom_range(0, 65535)),
                       MS_W'($urandom_range(0, 65535)), CLR_W'($urandom_range(1, 511)));
        queue_random_ticks(15);
        await_drain();

        apply_settings(RST_IDLE, RST_KEY1, RST_KEY2, RST_KEY3, RST_KEY4,
                       RST_LONG, RST_HOLD, RST_CLEAR);
        queue_random_ticks(80);
        await_drain();
        repeat (4) @(posedge i_clk);

        if (faults == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
